### hw/rtl/bwm_pkg.sv
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared types, constants and helpers for the basis world matrix builder.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int SQ_STEPS = 32;   // root bits of a 64-bit sum of squares

  localparam logic [37:0] SCL_LIM = 38'd214748364799;  // 100 * 2^31 - 1
  // ceil(2^41 / 25); exact floor(x / 25) for x < 25 * 2^31
  localparam logic [36:0] RCP_25  = 37'd87960930223;

  localparam logic [2:0] ROW_RIGHT = 3'd0;
  localparam logic [2:0] ROW_UP    = 3'd1;
  localparam logic [2:0] ROW_FWD   = 3'd2;
  localparam logic [2:0] ROW_POS   = 3'd3;
  localparam logic [2:0] ROW_DIR   = 3'd4;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic [2:0][31:0] scl;
    logic [2:0][31:0] pos;
  } car_t;

  typedef struct packed {
    logic [5:0]       neg;
    logic [5:0][31:0] mag;
  } nrm_t;

  function automatic s32_t sat32(input s64_t v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic s64_t smul(input s32_t a, input s32_t b);
    s64_t ea;
    s64_t eb;
    ea = 64'(a);
    eb = 64'(b);
    return ea * eb;
  endfunction

endpackage

### hw/rtl/basis_world_matrix_builder.sv
// ----------------------------------------------------------------------------
// basis_world_matrix_builder
// Look-at basis: normalizes forward and up, builds right and true up by cross
// products, emits three scaled rows, the position and the new direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_axis): forward, provisional up, per-axis scale and position,
//   twelve signed fixed-point words. Each accepted beat yields five output
//   beats on m_axis: right, up, forward rows (scaled by 0.01 * scale), the
//   position, then the normalized forward vector with tlast set; tuser
//   carries the row code.
//   Pipeline: the input beat passes 32 root steps, FRAC_BITS + 1 normalize
//   divide steps, then product, saturate and divide-by-100 stages, before
//   the first output beat is valid.
//   The five beats per item on the single output channel set the item rate;
//   the pipeline takes a new beat every cycle while the output register is
//   free.
//   Reset clears all valid bits and the output beat counter; s_axis_tready
//   is low while rst is high.
//   A stall on m_axis freezes the whole pipeline and drops s_axis_tready;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
module basis_world_matrix_builder #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dir_x, dir_y, dir_z, upv_x, upv_y, upv_z, scale_x, scale_y, scale_z,
  // pos_x, pos_y, pos_z (32 bits each, lowest first)
  input  logic [383:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vec_x, vec_y, vec_z (32 bits each, lowest first)
  output logic [95:0]  m_axis_tdata,
  // row_sel
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import bwm_pkg::*;

  localparam int DS  = FRAC_BITS + 1;
  localparam int NST = 1 + (SQ_STEPS + 1) + (DS + 1) + 6 + 2;

  logic       en;
  logic       vld [0:NST-1];
  logic       o_vld;
  logic [2:0] cnt;

  // stage A
  nrm_t        in_nrm;
  car_t        in_car;
  logic [63:0] a_sq [0:5];
  nrm_t        a_nrm;
  car_t        a_car;

  // square root
  logic [33:0] c_rem [0:SQ_STEPS][0:1];
  logic [31:0] c_root [0:SQ_STEPS][0:1];
  logic [63:0] c_s [0:SQ_STEPS-1][0:1];
  nrm_t        c_nrm [0:SQ_STEPS];
  car_t        c_car [0:SQ_STEPS];
  logic [33:0] c_rem_next [1:SQ_STEPS][0:1];
  logic [31:0] c_root_next [1:SQ_STEPS][0:1];

  // normalize divide
  logic [31:0]   d_rem [0:DS][0:5];
  logic [DS-1:0] d_q [0:DS][0:5];
  logic [31:0]   d_len [0:DS][0:1];
  nrm_t          d_nrm [0:DS];
  car_t          d_car [0:DS];
  logic [31:0]   d_rem_next [1:DS][0:5];
  logic [DS-1:0] d_q_next [1:DS][0:5];

  // cross products and scaling
  s32_t e_vec [0:5];
  car_t e_car;
  s64_t f_p [0:5];
  s32_t f_f [0:2];
  car_t f_car;
  s32_t g_r [0:2];
  s32_t g_f [0:2];
  car_t g_car;
  s64_t h_p [0:5];
  s32_t h_r [0:2];
  s32_t h_f [0:2];
  car_t h_car;
  s32_t i_t [0:2];
  s32_t i_r [0:2];
  s32_t i_f [0:2];
  car_t i_car;
  s64_t j_p [0:8];
  s32_t j_f [0:2];
  logic [2:0][31:0] j_pos;

  // divide by 100: drop two bits, then multiply by the reciprocal of 25
  s64_t        k_q [0:8];
  logic [63:0] k_n [0:8];
  logic [37:0] k_nc [0:8];
  logic [35:0] l_n [0:8];
  logic [8:0]  l_neg;
  s32_t        l_f [0:2];
  logic [2:0][31:0] l_pos;
  logic [35:0] m_lo [0:8];
  logic [37:0] m_mid [0:8];
  logic [36:0] m_hi [0:8];
  logic [8:0]  m_neg;
  s32_t        m_f [0:2];
  logic [2:0][31:0] m_pos;
  logic [73:0] n_sum [0:8];
  logic [30:0] n_q [0:8];

  // output register
  s32_t        o_row [0:8];
  s32_t        o_f [0:2];
  logic [31:0] o_pos [0:2];

  assign en            = !o_vld || (m_axis_tready && cnt == ROW_DIR);
  assign s_axis_tready = en && !rst;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_nrm.neg[i] = s_axis_tdata[32*i+31];
      in_nrm.mag[i] = in_nrm.neg[i] ? -s_axis_tdata[32*i +: 32] : s_axis_tdata[32*i +: 32];
    end
    for (int i = 0; i < 3; i++) begin
      in_car.scl[i] = s_axis_tdata[32*(6+i) +: 32];
      in_car.pos[i] = s_axis_tdata[32*(9+i) +: 32];
    end
  end

  always_comb begin
    logic [35:0] cur;
    logic [35:0] trial;
    for (int j = 1; j <= SQ_STEPS; j++) begin
      for (int v = 0; v < 2; v++) begin
        cur   = {c_rem[j-1][v], c_s[j-1][v][63-2*(j-1) -: 2]};
        trial = {2'b00, c_root[j-1][v], 2'b01};
        if (cur >= trial) begin
          c_rem_next[j][v]  = 34'(cur - trial);
          c_root_next[j][v] = {c_root[j-1][v][30:0], 1'b1};
        end else begin
          c_rem_next[j][v]  = cur[33:0];
          c_root_next[j][v] = {c_root[j-1][v][30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [32:0] cur;
    logic [32:0] lenx;
    for (int k = 1; k <= DS; k++) begin
      for (int i = 0; i < 6; i++) begin
        cur  = {d_rem[k-1][i], (k == 1) ? d_nrm[k-1].mag[i][0] : 1'b0};
        lenx = {1'b0, d_len[k-1][(i < 3) ? 0 : 1]};
        if (cur >= lenx) begin
          d_rem_next[k][i] = 32'(cur - lenx);
          d_q_next[k][i]   = {d_q[k-1][i][DS-2:0], 1'b1};
        end else begin
          d_rem_next[k][i] = cur[31:0];
          d_q_next[k][i]   = {d_q[k-1][i][DS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      k_q[i]  = j_p[i] >>> FRAC_BITS;
      k_n[i]  = k_q[i][63] ? ~k_q[i] : k_q[i];
      k_nc[i] = (k_n[i] > 64'(SCL_LIM)) ? SCL_LIM : k_n[i][37:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      n_sum[i] = 74'({m_hi[i], 36'd0}) + 74'({m_mid[i], 18'd0}) + 74'(m_lo[i]);
      n_q[i]   = n_sum[i][71:41];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int s = 1; s < NST; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        a_sq[i] <= in_nrm.mag[i] * in_nrm.mag[i];
      end
      a_nrm <= in_nrm;
      a_car <= in_car;

      for (int v = 0; v < 2; v++) begin
        c_rem[0][v]  <= '0;
        c_root[0][v] <= '0;
        c_s[0][v]    <= a_sq[3*v] + a_sq[3*v+1] + a_sq[3*v+2];
      end
      c_nrm[0] <= a_nrm;
      c_car[0] <= a_car;
      for (int j = 1; j <= SQ_STEPS; j++) begin
        for (int v = 0; v < 2; v++) begin
          c_rem[j][v]  <= c_rem_next[j][v];
          c_root[j][v] <= c_root_next[j][v];
          if (j < SQ_STEPS) begin
            c_s[j][v] <= c_s[j-1][v];
          end
        end
        c_nrm[j] <= c_nrm[j-1];
        c_car[j] <= c_car[j-1];
      end

      for (int i = 0; i < 6; i++) begin
        d_rem[0][i] <= c_nrm[SQ_STEPS].mag[i] >> 1;
        d_q[0][i]   <= '0;
      end
      for (int v = 0; v < 2; v++) begin
        d_len[0][v] <= c_root[SQ_STEPS][v];
      end
      d_nrm[0] <= c_nrm[SQ_STEPS];
      d_car[0] <= c_car[SQ_STEPS];
      for (int k = 1; k <= DS; k++) begin
        for (int i = 0; i < 6; i++) begin
          d_rem[k][i] <= d_rem_next[k][i];
          d_q[k][i]   <= d_q_next[k][i];
        end
        d_len[k] <= d_len[k-1];
        d_nrm[k] <= d_nrm[k-1];
        d_car[k] <= d_car[k-1];
      end

      for (int i = 0; i < 6; i++) begin
        if (d_len[DS][(i < 3) ? 0 : 1] == '0) begin
          e_vec[i] <= '0;
        end else if (d_nrm[DS].neg[i]) begin
          e_vec[i] <= -s32_t'(32'(d_q[DS][i]));
        end else begin
          e_vec[i] <= s32_t'(32'(d_q[DS][i]));
        end
      end
      e_car <= d_car[DS];

      // right = cross(up, forward)
      for (int c = 0; c < 3; c++) begin
        f_p[2*c]   <= smul(e_vec[3+(c+1)%3], e_vec[(c+2)%3]);
        f_p[2*c+1] <= smul(e_vec[3+(c+2)%3], e_vec[(c+1)%3]);
        f_f[c]     <= e_vec[c];
      end
      f_car <= e_car;

      for (int c = 0; c < 3; c++) begin
        g_r[c] <= sat32((f_p[2*c] - f_p[2*c+1]) >>> FRAC_BITS);
      end
      g_f   <= f_f;
      g_car <= f_car;

      // true up = cross(forward, right)
      for (int c = 0; c < 3; c++) begin
        h_p[2*c]   <= smul(g_f[(c+1)%3], g_r[(c+2)%3]);
        h_p[2*c+1] <= smul(g_f[(c+2)%3], g_r[(c+1)%3]);
      end
      h_r   <= g_r;
      h_f   <= g_f;
      h_car <= g_car;

      for (int c = 0; c < 3; c++) begin
        i_t[c] <= sat32((h_p[2*c] - h_p[2*c+1]) >>> FRAC_BITS);
      end
      i_r   <= h_r;
      i_f   <= h_f;
      i_car <= h_car;

      for (int c = 0; c < 3; c++) begin
        j_p[c]   <= smul(i_r[c], i_car.scl[0]);
        j_p[3+c] <= smul(i_t[c], i_car.scl[1]);
        j_p[6+c] <= smul(i_f[c], i_car.scl[2]);
      end
      j_f   <= i_f;
      j_pos <= i_car.pos;

      for (int i = 0; i < 9; i++) begin
        l_n[i]   <= k_nc[i][37:2];
        l_neg[i] <= k_q[i][63];
      end
      l_f   <= j_f;
      l_pos <= j_pos;

      for (int i = 0; i < 9; i++) begin
        m_lo[i]  <= 36'(l_n[i][17:0]) * 36'(RCP_25[17:0]);
        m_mid[i] <= 38'(l_n[i][17:0]) * 38'(RCP_25[36:18])
                  + 38'(l_n[i][35:18]) * 38'(RCP_25[17:0]);
        m_hi[i]  <= 37'(l_n[i][35:18]) * 37'(RCP_25[36:18]);
      end
      m_neg <= l_neg;
      m_f   <= l_f;
      m_pos <= l_pos;

      for (int i = 0; i < 9; i++) begin
        o_row[i] <= m_neg[i] ? ~{1'b0, n_q[i]} : {1'b0, n_q[i]};
      end
      for (int c = 0; c < 3; c++) begin
        o_f[c]   <= m_f[c];
        o_pos[c] <= m_pos[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      cnt   <= ROW_RIGHT;
    end else if (en) begin
      o_vld <= vld[NST-1];
      cnt   <= ROW_RIGHT;
    end else if (m_axis_tready) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_comb begin
    case (cnt)
      ROW_RIGHT: m_axis_tdata = {o_row[2], o_row[1], o_row[0]};
      ROW_UP:    m_axis_tdata = {o_row[5], o_row[4], o_row[3]};
      ROW_FWD:   m_axis_tdata = {o_row[8], o_row[7], o_row[6]};
      ROW_POS:   m_axis_tdata = {o_pos[2], o_pos[1], o_pos[0]};
      ROW_DIR:   m_axis_tdata = {o_f[2], o_f[1], o_f[0]};
      default:   m_axis_tdata = '0;
    endcase
  end

  assign m_axis_tvalid = o_vld;
  assign m_axis_tuser  = cnt;
  assign m_axis_tlast  = (cnt == ROW_DIR);

endmodule

### bench/basis_world_matrix_builder_test.sv
// ----------------------------------------------------------------------------
// basis_world_matrix_builder_test
// Streams look-at items into the basis builder and checks all five output
// beats per item against a fixed-point model kept in the bench. Directed
// items cover axes, zero-length vectors and extreme words. Random items
// follow, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module basis_world_matrix_builder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bwm_pkg::*;

  localparam int FB = 16;
  localparam int WATCH_LIMIT = 4000;
  localparam int TAIL = FB + 120;

  typedef struct {
    logic [2:0]  sel;
    logic [31:0] x, y, z;
    logic        last;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [383:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  row_t row_queue[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   gap_left = 0;

  basis_world_matrix_builder #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #2 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_floor(longint p, longint d);
    if (p >= 0) return p / d;
    return -((-p + d - 1) / d);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic unit_vec(input longint v[3], output longint o[3]);
    longint unsigned s, len, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      s = s + m * m;
    end
    if (s == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
    end else begin
      len = root64(s);
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        m = (m << FB) / len;
        o[i] = v[i] < 0 ? -longint'(m) : longint'(m);
      end
    end
  endtask

  function automatic longint cross_part(longint a1, longint b2, longint a2, longint b1);
    return clamp32(div_floor(a1 * b2 - a2 * b1, 64'sd1 << FB));
  endfunction

  task automatic cross_vec(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = cross_part(a[1], b[2], a[2], b[1]);
    o[1] = cross_part(a[2], b[0], a[0], b[2]);
    o[2] = cross_part(a[0], b[1], a[1], b[0]);
  endtask

  function automatic row_t make_row(logic [2:0] sel, longint v[3], longint s, bit scaled);
    row_t r;
    longint c[3];
    for (int i = 0; i < 3; i++)
      c[i] = scaled ? clamp32(div_floor(v[i] * s, 64'sd100 << FB)) : clamp32(v[i]);
    r.sel = sel;
    r.x = c[0][31:0];
    r.y = c[1][31:0];
    r.z = c[2][31:0];
    r.last = (sel == ROW_DIR);
    return r;
  endfunction

  task automatic predict_rows(input logic [383:0] d);
    longint dir[3], upv[3], scl[3], pos[3];
    longint f[3], u[3], r[3], t[3];
    for (int i = 0; i < 3; i++) begin
      dir[i] = longint'($signed(d[32*i +: 32]));
      upv[i] = longint'($signed(d[32*(3+i) +: 32]));
      scl[i] = longint'($signed(d[32*(6+i) +: 32]));
      pos[i] = longint'($signed(d[32*(9+i) +: 32]));
    end
    unit_vec(dir, f);
    unit_vec(upv, u);
    cross_vec(u, f, r);
    cross_vec(f, r, t);
    row_queue.push_back(make_row(ROW_RIGHT, r, scl[0], 1'b1));
    row_queue.push_back(make_row(ROW_UP, t, scl[1], 1'b1));
    row_queue.push_back(make_row(ROW_FWD, f, scl[2], 1'b1));
    row_queue.push_back(make_row(ROW_POS, pos, 0, 1'b0));
    row_queue.push_back(make_row(ROW_DIR, f, 0, 1'b0));
  endtask

  // one input beat; holds valid between back-to-back beats
  task automatic send_item(input logic [383:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    predict_rows(d);
    if (gap_left == 0 && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
    if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      gap_left--;
    end
  endtask

  function automatic logic [383:0] pack_item(logic [31:0] w[12]);
    logic [383:0] d;
    for (int i = 0; i < 12; i++) d[32*i +: 32] = w[i];
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (row_queue.size() == 0) begin
        report_mismatch("unexpected beat", {29'd0, m_axis_tuser}, 32'd0);
      end else begin
        row_t e;
        e = row_queue.pop_front();
        if (m_axis_tuser !== e.sel) report_mismatch("row_sel", {29'd0, m_axis_tuser}, {29'd0, e.sel});
        if (m_axis_tdata[31:0] !== e.x) report_mismatch("vec_x", m_axis_tdata[31:0], e.x);
        if (m_axis_tdata[63:32] !== e.y) report_mismatch("vec_y", m_axis_tdata[63:32], e.y);
        if (m_axis_tdata[95:64] !== e.z) report_mismatch("vec_z", m_axis_tdata[95:64], e.z);
        if (m_axis_tlast !== e.last) report_mismatch("last", {31'd0, m_axis_tlast}, {31'd0, e.last});
      end
    end
  end

  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[9:7])
      3'd0, 3'd4: m_axis_tready <= 1'b1;
      3'd1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      3'd2: m_axis_tready <= (cyc[2:0] != 3'd0);
      3'd3: m_axis_tready <= (cyc[4:0] < 5'd20);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
      2: return 32'($signed($urandom_range(0, 200 << FB)) - (100 << FB));
      3: return {32{$urandom_range(0, 1) == 1}} ^ 32'($urandom_range(0, 255));
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic test_axes();
    logic [31:0] w[12];
    logic [31:0] one, s;
    one = 32'd1 << FB;
    s = 32'd100 << FB;
    w = '{one, 0, 0, 0, one, 0, s, s, s, 32'd5, 32'd6, 32'd7};
    send_item(pack_item(w));
    w = '{0, 0, one, 0, one, 0, s, s, s, 0, 0, 0};
    send_item(pack_item(w));
    w = '{0, -one, 0, one, 0, 0, one, one, one, 1, 2, 3};
    send_item(pack_item(w));
    w = '{one, one, one, 0, one, 0, -s, s, -s, -1, -2, -3};
    send_item(pack_item(w));
    w = '{3 * one, 4 * one, 0, 0, 0, one, s, 2 * s, 3 * s, 9, 8, 7};
    send_item(pack_item(w));
  endtask

  task automatic test_zero_length();
    logic [31:0] w[12];
    w = '{0, 0, 0, 0, 32'd1 << FB, 0, 32'hffffffff, 32'h7fffffff, 32'h80000000, 1, 2, 3};
    send_item(pack_item(w));
    w = '{32'd1 << FB, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 4, 5, 6};
    send_item(pack_item(w));
    w = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_item(pack_item(w));
    w = '{0, 0, 1, 0, 0, 0, 1, 1, 1, 0, 0, 0};
    send_item(pack_item(w));
  endtask

  task automatic test_extremes();
    logic [31:0] w[12];
    logic [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    w = '{mx, mx, mx, mn, mn, mn, mx, mx, mx, mx, mx, mx};
    send_item(pack_item(w));
    w = '{mn, mn, mn, mx, mn, mx, mn, mn, mn, mn, mn, mn};
    send_item(pack_item(w));
    w = '{mn, 0, 0, 0, mn, 0, mx, mn, mx, mn, mx, mn};
    send_item(pack_item(w));
    w = '{1, 0, 0, 0, 0, 1, mx, mx, mx, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    send_item(pack_item(w));
    w = '{32'hffffffff, 1, 32'hffffffff, 1, 1, 1, mn, mx, mn, 32'h55555555, 32'haaaaaaaa, 0};
    send_item(pack_item(w));
    w = '{mx, 1, 0, mx, 0, 1, mx, mx, mx, 0, 0, 0};
    send_item(pack_item(w));
  endtask

  task automatic test_random(input int count);
    logic [31:0] w[12];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 12; i++) w[i] = rand_word();
      if ($urandom_range(0, 15) == 0) begin
        w[0] = 0; w[1] = 0; w[2] = 0;
      end
      if ($urandom_range(0, 15) == 0) begin
        w[3] = 0; w[4] = 0; w[5] = 0;
      end
      send_item(pack_item(w));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axes();
    test_zero_length();
    test_extremes();
    test_random(315);
    s_axis_tvalid <= 1'b0;
    while (row_queue.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
